// ===== design/drm_pkg.sv =====
// Shared constants, types and helper functions for the drag-to-rotation core.
// No dependencies; every other design file imports this package.
`default_nettype none

package drm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   localparam int ROOT_BITS = 32;   // length root, one bit per stage
   localparam int QUO_BITS  = 17;   // unit vector quotient, one bit per stage

   localparam logic signed [17:0] ONE_Q16      = 18'sd65536;
   localparam logic [23:0]        APU_RESET    = 24'd167772;
   localparam logic [29:0]        TURN_PER_RAD = 30'd683565276;  // 2^32 / (2 pi)

   // arctangent table in turns, Q0.32
   localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   function automatic logic [63:0] isqrt64(input logic [63:0] num_arg);
      logic [63:0] num;
      logic [63:0] res;
      logic [63:0] bit_v;
      num   = num_arg;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (num >= res + bit_v) begin
            num = num - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // CORDIC gain in Q.28 after n steps
   function automatic logic [63:0] gain_q28(input int n);
      logic [63:0] k;
      logic [63:0] sq;
      k = 64'd1 << 28;
      for (int i = 0; i < ATAN_ENTRIES; i++) begin
         if (i < n) begin
            sq = k * k;
            sq = sq + (sq >> (2 * i));
            k  = isqrt64(sq);
         end
      end
      return k;
   endfunction

   localparam logic [63:0] GAIN_Q28 = gain_q28(STEPS);
   localparam logic [63:0] X0_Q30   = (64'd1 << 58) / GAIN_Q28;

   function automatic logic signed [17:0] cap_one(input logic signed [39:0] a);
      logic signed [17:0] r;
      if (a > 40'sd65536) begin
         r = ONE_Q16;
      end else if (a < -40'sd65536) begin
         r = -ONE_Q16;
      end else begin
         r = a[17:0];
      end
      return r;
   endfunction

   typedef logic signed [17:0] q16_type;

   typedef struct packed {
      logic        zero;
      logic        neg_x;
      logic        neg_y;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
   } drag_type;

   typedef struct packed {
      logic        zero;
      logic [31:0] len;
      q16_type     ux;
      q16_type     uy;
   } unit_type;

   typedef struct packed {
      q16_type c;
      q16_type s;
   } trig_type;

endpackage

`default_nettype wire

// ===== design/drm_isqrt.sv =====
// Pipelined integer square root of the drag's sum of squares (its length), one root bit per stage.
// Depends on drm_pkg.
`default_nettype none

module drm_isqrt
   import drm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire drag_type    in_drag,
   input  wire logic [31:0] in_sumsq,
   output logic             out_valid,
   output drag_type         out_drag,
   output logic [31:0]      out_len
);

   logic        valid_ff [ROOT_BITS];
   drag_type    drag_ff  [ROOT_BITS];
   logic [35:0] rem_ff   [ROOT_BITS];
   logic [31:0] root_ff  [ROOT_BITS];
   logic [31:0] num_ff   [ROOT_BITS];

   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
      logic        v_src;
      drag_type    d_src;
      logic [35:0] rem_src;
      logic [31:0] root_src;
      logic [31:0] num_src;
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic [35:0] rem_in;
      logic [31:0] root_in;
      logic [31:0] num_in;

      if (g == 0) begin : g_first
         assign v_src    = in_valid;
         assign d_src    = in_drag;
         assign rem_src  = '0;
         assign root_src = '0;
         assign num_src  = in_sumsq;   // low 32 bits of the radicand are zero
      end else begin : g_next
         assign v_src    = valid_ff[g-1];
         assign d_src    = drag_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign num_src  = num_ff[g-1];
      end

      always_comb begin
         rem_sh = {rem_src[33:0], num_src[31:30]};
         trial  = {2'b00, root_src, 2'b01};
         num_in = {num_src[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_src[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_src[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_src;
         end
         if (en) begin
            drag_ff[g] <= d_src;
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            num_ff[g]  <= num_in;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_drag  = drag_ff[ROOT_BITS-1];
   assign out_len   = root_ff[ROOT_BITS-1];

endmodule

`default_nettype wire

// ===== design/drm_unit.sv =====
// Unit axis: two restoring dividers, |y|*2^32/len and |x|*2^32/len, one bit a stage.
// Depends on drm_pkg.
`default_nettype none

module drm_unit
   import drm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire drag_type    in_drag,
   input  wire logic [31:0] in_len,
   output logic             out_valid,
   output unit_type         out_unit
);

   // lane 0 divides |y| (gives ux), lane 1 divides |x| (gives uy)
   logic                valid_ff [QUO_BITS];
   drag_type            drag_ff  [QUO_BITS];
   logic [31:0]         len_ff   [QUO_BITS];
   logic [1:0][48:0]    rem_ff   [QUO_BITS];
   logic [1:0][QUO_BITS-1:0] quo_ff [QUO_BITS];

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
      localparam int SH = QUO_BITS - 1 - g;
      logic                     v_src;
      drag_type                 d_src;
      logic [31:0]              len_src;
      logic [1:0][48:0]         rem_src;
      logic [1:0][QUO_BITS-1:0] quo_src;
      logic [48:0]              dsh;
      logic [1:0][48:0]         rem_in;
      logic [1:0][QUO_BITS-1:0] quo_in;

      if (g == 0) begin : g_first
         assign v_src      = in_valid;
         assign d_src      = in_drag;
         assign len_src    = in_len;
         assign rem_src[0] = {1'b0, in_drag.mag_y, 32'd0};
         assign rem_src[1] = {1'b0, in_drag.mag_x, 32'd0};
         assign quo_src    = '0;
      end else begin : g_next
         assign v_src   = valid_ff[g-1];
         assign d_src   = drag_ff[g-1];
         assign len_src = len_ff[g-1];
         assign rem_src = rem_ff[g-1];
         assign quo_src = quo_ff[g-1];
      end

      always_comb begin
         dsh    = {17'd0, len_src} << SH;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int l = 0; l < 2; l++) begin
            if (rem_src[l] >= dsh) begin
               rem_in[l]     = rem_src[l] - dsh;
               quo_in[l][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_src;
         end
         if (en) begin
            drag_ff[g] <= d_src;
            len_ff[g]  <= len_src;
            rem_ff[g]  <= rem_in;
            quo_ff[g]  <= quo_in;
         end
      end
   end

   logic [1:0][16:0] mag;
   drag_type         last;

   always_comb begin
      last = drag_ff[QUO_BITS-1];
      for (int l = 0; l < 2; l++) begin
         mag[l] = (quo_ff[QUO_BITS-1][l] > 17'd65536) ? 17'd65536 : quo_ff[QUO_BITS-1][l];
      end
      out_unit.zero = last.zero;
      out_unit.len  = len_ff[QUO_BITS-1];
      out_unit.ux   = last.neg_y ? -$signed({1'b0, mag[0]}) : $signed({1'b0, mag[0]});
      out_unit.uy   = last.neg_x ? -$signed({1'b0, mag[1]}) : $signed({1'b0, mag[1]});
   end

   assign out_valid = valid_ff[QUO_BITS-1];

endmodule

`default_nettype wire

// ===== design/drm_sincos.sv =====
// Angle to phase in turns, then an unrolled rotation CORDIC giving cos and sin.
// Depends on drm_pkg.
`default_nettype none

module drm_sincos
   import drm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic [23:0] apu,
   input  wire logic        in_valid,
   input  wire unit_type    in_unit,
   output logic             out_valid,
   output unit_type         out_unit,
   output trig_type         out_trig
);

   // phase stage 1: radians in Q.32
   logic        p1_valid_ff;
   unit_type    p1_unit_ff;
   logic [47:0] rad_ff;
   logic [55:0] rad_prod;

   assign rad_prod = 56'(apu) * 56'(in_unit.len);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
      end
      if (en) begin
         p1_unit_ff <= in_unit;
         rad_ff     <= rad_prod[55:8];
      end
   end

   // phase stage 2: partial products of rad * turns-per-radian
   logic        p2_valid_ff;
   unit_type    p2_unit_ff;
   logic [53:0] plo_ff;
   logic [53:0] phi_ff;
   logic [53:0] plo_in;
   logic [53:0] phi_in;

   assign plo_in = 54'(rad_ff[23:0]) * 54'(TURN_PER_RAD);
   assign phi_in = 54'(rad_ff[47:24]) * 54'(TURN_PER_RAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         p2_unit_ff <= p1_unit_ff;
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
      end
   end

   // phase stage 3: sum mod 2^64, keep the upper word as turns
   logic        p3_valid_ff;
   unit_type    p3_unit_ff;
   logic [31:0] phase_ff;
   logic [63:0] phase_sum;

   assign phase_sum = 64'(plo_ff) + {phi_ff[39:0], 24'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (en) begin
         p3_unit_ff <= p2_unit_ff;
         phase_ff   <= phase_sum[63:32];
      end
   end

   // CORDIC, one micro-rotation per stage
   logic               cv_valid_ff [STEPS];
   unit_type           cv_unit_ff  [STEPS];
   logic [1:0]         quad_ff     [STEPS];
   logic signed [33:0] x_ff        [STEPS];
   logic signed [33:0] y_ff        [STEPS];
   logic signed [32:0] z_ff        [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic               v_src;
      unit_type           u_src;
      logic [1:0]         q_src;
      logic signed [33:0] x_src;
      logic signed [33:0] y_src;
      logic signed [32:0] z_src;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [32:0] at;
      logic signed [33:0] x_in;
      logic signed [33:0] y_in;
      logic signed [32:0] z_in;

      if (g == 0) begin : g_first
         assign v_src = p3_valid_ff;
         assign u_src = p3_unit_ff;
         assign q_src = phase_ff[31:30];
         assign x_src = $signed(X0_Q30[33:0]);
         assign y_src = '0;
         assign z_src = $signed({3'b000, phase_ff[29:0]});
      end else begin : g_next
         assign v_src = cv_valid_ff[g-1];
         assign u_src = cv_unit_ff[g-1];
         assign q_src = quad_ff[g-1];
         assign x_src = x_ff[g-1];
         assign y_src = y_ff[g-1];
         assign z_src = z_ff[g-1];
      end

      always_comb begin
         dx = y_src >>> g;
         dy = x_src >>> g;
         at = $signed({1'b0, ATAN_TURNS[g]});
         if (!z_src[32]) begin
            x_in = x_src - dx;
            y_in = y_src + dy;
            z_in = z_src - at;
         end else begin
            x_in = x_src + dx;
            y_in = y_src - dy;
            z_in = z_src + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_valid_ff[g] <= 1'b0;
         end else if (en) begin
            cv_valid_ff[g] <= v_src;
         end
         if (en) begin
            cv_unit_ff[g] <= u_src;
            quad_ff[g]    <= q_src;
            x_ff[g]       <= x_in;
            y_ff[g]       <= y_in;
            z_ff[g]       <= z_in;
         end
      end
   end

   // round Q.30 to Q.16, cap, fold in the quadrant
   logic               post_valid_ff;
   unit_type           post_unit_ff;
   trig_type           trig_ff;
   trig_type           trig_in;
   logic signed [33:0] xr;
   logic signed [33:0] yr;
   q16_type            c0;
   q16_type            s0;

   always_comb begin
      xr = (x_ff[STEPS-1] + 34'sd8192) >>> 14;
      yr = (y_ff[STEPS-1] + 34'sd8192) >>> 14;
      c0 = cap_one(40'(xr));
      s0 = cap_one(40'(yr));
      case (quad_ff[STEPS-1])
         2'd0: begin
            trig_in.c = c0;
            trig_in.s = s0;
         end
         2'd1: begin
            trig_in.c = -s0;
            trig_in.s = c0;
         end
         2'd2: begin
            trig_in.c = -c0;
            trig_in.s = -s0;
         end
         default: begin
            trig_in.c = s0;
            trig_in.s = -c0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
      end else if (en) begin
         post_valid_ff <= cv_valid_ff[STEPS-1];
      end
      if (en) begin
         post_unit_ff <= cv_unit_ff[STEPS-1];
         trig_ff      <= trig_in;
      end
   end

   assign out_valid = post_valid_ff;
   assign out_unit  = post_unit_ff;
   assign out_trig  = trig_ff;

endmodule

`default_nettype wire

// ===== design/drm_compose.sv =====
// Rodrigues composition of the matrix from the unit axis and cos/sin; two stages,
// the second is the result register. Depends on drm_pkg.
`default_nettype none

module drm_compose
   import drm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire unit_type in_unit,
   input  wire trig_type in_trig,
   output logic          out_valid,
   output q16_type       out_m00,
   output q16_type       out_m01,
   output q16_type       out_m02,
   output q16_type       out_m10,
   output q16_type       out_m11,
   output q16_type       out_m12,
   output q16_type       out_m20,
   output q16_type       out_m21,
   output q16_type       out_m22
);

   // stage A: axis outer products and sine terms
   logic               a_valid_ff;
   logic               a_zero_ff;
   q16_type            a_c_ff;
   logic signed [18:0] a_omc_ff;
   q16_type            uxx_ff;
   q16_type            uxy_ff;
   q16_type            uyy_ff;
   q16_type            sx_ff;
   q16_type            sy_ff;

   logic signed [35:0] pxx;
   logic signed [35:0] pxy;
   logic signed [35:0] pyy;
   logic signed [35:0] psx;
   logic signed [35:0] psy;
   logic signed [35:0] rxx;
   logic signed [35:0] rxy;
   logic signed [35:0] ryy;
   logic signed [35:0] rsx;
   logic signed [35:0] rsy;

   always_comb begin
      pxx = in_unit.ux * in_unit.ux;
      pxy = in_unit.ux * in_unit.uy;
      pyy = in_unit.uy * in_unit.uy;
      psx = in_trig.s * in_unit.ux;
      psy = in_trig.s * in_unit.uy;
      rxx = (pxx + 36'sd32768) >>> 16;
      rxy = (pxy + 36'sd32768) >>> 16;
      ryy = (pyy + 36'sd32768) >>> 16;
      rsx = (psx + 36'sd32768) >>> 16;
      rsy = (psy + 36'sd32768) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
      if (en) begin
         a_zero_ff <= in_unit.zero;
         a_c_ff    <= in_trig.c;
         a_omc_ff  <= 19'sd65536 - 19'(in_trig.c);
         uxx_ff    <= rxx[17:0];
         uxy_ff    <= rxy[17:0];
         uyy_ff    <= ryy[17:0];
         sx_ff     <= rsx[17:0];
         sy_ff     <= rsy[17:0];
      end
   end

   // stage B: (1 - c) terms, caps, identity for zero drag
   logic               out_valid_ff;
   q16_type            m00_ff, m01_ff, m02_ff, m10_ff, m11_ff, m12_ff, m20_ff, m21_ff, m22_ff;
   q16_type            m00_in, m01_in, m02_in, m10_in, m11_in, m12_in, m20_in, m21_in, m22_in;
   logic signed [36:0] bxx;
   logic signed [36:0] bxy;
   logic signed [36:0] byy;

   always_comb begin
      bxx = (a_omc_ff * uxx_ff + 37'sd32768) >>> 16;
      bxy = (a_omc_ff * uxy_ff + 37'sd32768) >>> 16;
      byy = (a_omc_ff * uyy_ff + 37'sd32768) >>> 16;
      if (a_zero_ff) begin
         m00_in = ONE_Q16;
         m01_in = '0;
         m02_in = '0;
         m10_in = '0;
         m11_in = ONE_Q16;
         m12_in = '0;
         m20_in = '0;
         m21_in = '0;
         m22_in = ONE_Q16;
      end else begin
         m00_in = cap_one(40'(a_c_ff) + 40'(bxx));
         m01_in = cap_one(40'(bxy));
         m02_in = cap_one(40'(sy_ff));
         m10_in = m01_in;
         m11_in = cap_one(40'(a_c_ff) + 40'(byy));
         m12_in = cap_one(-40'(sx_ff));
         m20_in = cap_one(-40'(sy_ff));
         m21_in = cap_one(40'(sx_ff));
         m22_in = cap_one(40'(a_c_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= a_valid_ff;
      end
      if (en) begin
         m00_ff <= m00_in;
         m01_ff <= m01_in;
         m02_ff <= m02_in;
         m10_ff <= m10_in;
         m11_ff <= m11_in;
         m12_ff <= m12_in;
         m20_ff <= m20_in;
         m21_ff <= m21_in;
         m22_ff <= m22_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_m00   = m00_ff;
   assign out_m01   = m01_ff;
   assign out_m02   = m02_ff;
   assign out_m10   = m10_ff;
   assign out_m11   = m11_ff;
   assign out_m12   = m12_ff;
   assign out_m20   = m20_ff;
   assign out_m21   = m21_ff;
   assign out_m22   = m22_ff;

   // rotation matrix symmetry of the composed terms, and the result held during a stall
   assert property (@(posedge clock) disable iff (reset) out_valid_ff |-> m01_ff == m10_ff)
      else $error("m01 and m10 differ");
   assert property (@(posedge clock) disable iff (reset) out_valid_ff |-> m20_ff == -m02_ff)
      else $error("m20 is not the negated m02");
   assert property (@(posedge clock) disable iff (reset) out_valid_ff |-> m12_ff == -m21_ff)
      else $error("m12 is not the negated m21");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !en |=> out_valid_ff && $stable(m00_ff) && $stable(m22_ff))
      else $error("held result changed during stall");

endmodule

`default_nettype wire

// ===== design/drag_to_rotation_matrix_core.sv =====
// Drag-to-rotation core: one drag (dx, dy) in, one 3x3 rotation matrix out.
// Depends on drm_pkg, drm_isqrt, drm_unit, drm_sincos, drm_compose.
`default_nettype none

// Usage
//   Request channel: req_valid/req_ready with req_drag_x, req_drag_y (signed
//   integer units). Result channel: rsp_valid/rsp_ready with rsp_m00..rsp_m22,
//   signed Q1.16, row-major. A request is taken on a clock edge where valid
//   and ready are both high; the same holds for a result.
//   csr_write_enable/csr_write_data load angle_per_unit (unsigned Q0.24,
//   radians per unit drag); write it only while the pipe is empty.
//   Throughput: one request per cycle while no result is stalled. The pipe has
//   56 + STEPS register stages (72 at 16 CORDIC steps): the input register, the
//   32-stage length root, the 17-stage axis divider, 3 phase stages, the CORDIC
//   stages, one rounding stage and two composition stages, the last being the
//   result register.
//   Zero drag returns the identity matrix.
//   Reset (synchronous, active high) empties the pipe and restores
//   angle_per_unit to its reset value.
//   Stall: while a result waits with rsp_ready low, every stage holds and
//   req_ready drops, even with bubbles in the pipe (req_ready follows rsp_ready).

module drag_to_rotation_matrix_core
   import drm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_drag_x,
   input  wire logic [15:0] req_drag_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output q16_type          rsp_m00,
   output q16_type          rsp_m01,
   output q16_type          rsp_m02,
   output q16_type          rsp_m10,
   output q16_type          rsp_m11,
   output q16_type          rsp_m12,
   output q16_type          rsp_m20,
   output q16_type          rsp_m21,
   output q16_type          rsp_m22,
   input  wire logic        csr_write_enable,
   input  wire logic [23:0] csr_write_data
);

   logic [23:0] apu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         apu_ff <= APU_RESET;
      end else if (csr_write_enable) begin
         apu_ff <= csr_write_data;
      end
   end

   // whole pipe advances unless the result register is full and stalled
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // input stage: magnitudes, signs, sum of squares
   logic        s0_valid_ff;
   drag_type    s0_drag_ff;
   logic [31:0] s0_sumsq_ff;
   drag_type    drag_in;
   logic [31:0] sumsq_in;

   always_comb begin
      drag_in.neg_x = req_drag_x[15];
      drag_in.neg_y = req_drag_y[15];
      drag_in.mag_x = req_drag_x[15] ? (16'd0 - req_drag_x) : req_drag_x;
      drag_in.mag_y = req_drag_y[15] ? (16'd0 - req_drag_y) : req_drag_y;
      drag_in.zero  = (req_drag_x == 16'd0) && (req_drag_y == 16'd0);
      sumsq_in      = 32'(drag_in.mag_x) * 32'(drag_in.mag_x)
                    + 32'(drag_in.mag_y) * 32'(drag_in.mag_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
      if (en) begin
         s0_drag_ff  <= drag_in;
         s0_sumsq_ff <= sumsq_in;
      end
   end

   logic        len_valid;
   drag_type    len_drag;
   logic [31:0] len;

   drm_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_drag   (s0_drag_ff),
      .in_sumsq  (s0_sumsq_ff),
      .out_valid (len_valid),
      .out_drag  (len_drag),
      .out_len   (len)
   );

   logic     unit_valid;
   unit_type unit_axis;

   drm_unit u_unit (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (len_valid),
      .in_drag   (len_drag),
      .in_len    (len),
      .out_valid (unit_valid),
      .out_unit  (unit_axis)
   );

   logic     trig_valid;
   unit_type trig_unit;
   trig_type trig;

   drm_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .apu       (apu_ff),
      .in_valid  (unit_valid),
      .in_unit   (unit_axis),
      .out_valid (trig_valid),
      .out_unit  (trig_unit),
      .out_trig  (trig)
   );

   drm_compose u_compose (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (trig_valid),
      .in_unit   (trig_unit),
      .in_trig   (trig),
      .out_valid (rsp_valid),
      .out_m00   (rsp_m00),
      .out_m01   (rsp_m01),
      .out_m02   (rsp_m02),
      .out_m10   (rsp_m10),
      .out_m11   (rsp_m11),
      .out_m12   (rsp_m12),
      .out_m20   (rsp_m20),
      .out_m21   (rsp_m21),
      .out_m22   (rsp_m22)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for drag_to_rotation_matrix_core: directed and random drags, checked
// against an in-bench bit-exact predictor. Depends on drm_pkg and the core RTL.
`default_nettype none

module tb_top;
   import drm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 56 + STEPS;
   localparam int WATCHDOG  = 4000;

   // arctangent table in turns, kept locally so prediction stands apart
   localparam logic [31:0] ATAN_T [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct {
      logic signed [17:0] m [9];
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_drag_x = '0;
   logic [15:0] req_drag_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   q16_type rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12, rsp_m20, rsp_m21, rsp_m22;
   logic csr_write_enable = 1'b0;
   logic [23:0] csr_write_data = '0;

   logic [23:0] rad_per_unit;   // predictor's copy of the register
   matrix_type  matrix_queue [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          stall_mode = 1'b1;   // when clear, receiver never stalls

   drag_to_rotation_matrix_core dut (
      .clock, .reset, .req_valid, .req_ready, .req_drag_x, .req_drag_y,
      .rsp_valid, .rsp_ready, .rsp_m00, .rsp_m01, .rsp_m02, .rsp_m10, .rsp_m11,
      .rsp_m12, .rsp_m20, .rsp_m21, .rsp_m22, .csr_write_enable, .csr_write_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint floor_sh(longint a, int k);
      return a >>> k;   // arithmetic shift is floor on two's complement
   endfunction

   function automatic longint round_sh(longint a, int k);
      return (a + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clamp_one(longint a);
      if (a > longint'(65536)) return longint'(65536);
      if (a < longint'(-65536)) return longint'(-65536);
      return a;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] num_in);
      logic [63:0] num, res, b;
      num = num_in;
      res = '0;
      b = 64'd1 << 62;
      while (b > num) b = b >> 2;
      while (b != 0) begin
         if (num >= res + b) begin
            num = num - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint start_x(int n);
      logic [63:0] k, sq;
      k = 64'd1 << 28;
      for (int i = 0; i < n; i++) begin
         sq = k * k;
         sq = sq + (sq >> (2 * i));
         k = int_sqrt(sq);
      end
      return longint'((64'd1 << 58) / k);
   endfunction

   function automatic longint axis_part(longint comp, logic [63:0] len);
      logic [63:0] mag, q;
      mag = (comp < 0) ? -comp : comp;
      q = (mag << 32) / len;
      if (q > 64'd65536) q = 64'd65536;
      return (comp < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic matrix_type rotation_of_drag(logic [15:0] dxr, logic [15:0] dyr);
      matrix_type r;
      longint x, y, m [9], ux, uy, c, s, cx, cy, z, omc, uxx, uxy, uyy, sx, sy, ddx, ddy;
      logic [63:0] len, rad, prod;
      logic [31:0] phase;
      int n;
      x = longint'($signed(dxr));
      y = longint'($signed(dyr));
      n = STEPS;
      if (x == 0 && y == 0) begin
         for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? longint'(65536) : longint'(0);
      end else begin
         len = int_sqrt(64'(x * x + y * y) << 32);
         ux = axis_part(y, len);
         uy = axis_part(x, len);
         rad = (64'(rad_per_unit) * len) >> 8;
         prod = rad * 64'd683565276;
         phase = prod[63:32];
         z = longint'(phase[29:0]);
         cx = start_x(n);
         cy = 0;
         for (int i = 0; i < n; i++) begin
            ddx = floor_sh(cy, i);
            ddy = floor_sh(cx, i);
            if (z >= 0) begin
               cx -= ddx; cy += ddy; z -= longint'(ATAN_T[i]);
            end else begin
               cx += ddx; cy -= ddy; z += longint'(ATAN_T[i]);
            end
         end
         cx = clamp_one(round_sh(cx, 14));
         cy = clamp_one(round_sh(cy, 14));
         case (phase[31:30])
            2'd0: begin c = cx;  s = cy;  end
            2'd1: begin c = -cy; s = cx;  end
            2'd2: begin c = -cx; s = -cy; end
            default: begin c = cy; s = -cx; end
         endcase
         omc = longint'(65536) - c;
         uxx = round_sh(ux * ux, 16);
         uxy = round_sh(ux * uy, 16);
         uyy = round_sh(uy * uy, 16);
         sx = round_sh(s * ux, 16);
         sy = round_sh(s * uy, 16);
         m[0] = c + round_sh(omc * uxx, 16);
         m[1] = round_sh(omc * uxy, 16);
         m[2] = sy;
         m[3] = m[1];
         m[4] = c + round_sh(omc * uyy, 16);
         m[5] = -sx;
         m[6] = -sy;
         m[7] = sx;
         m[8] = c;
      end
      for (int k = 0; k < 9; k++) r.m[k] = 18'(clamp_one(m[k]));
      return r;
   endfunction

   // ---------------- drivers ----------------
   // called at a falling edge; leaves valid high after acceptance so that a
   // following request with no gap stays back to back
   task automatic send_drag(logic [15:0] dx, logic [15:0] dy);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_drag_x <= dx;
      req_drag_y <= dy;
      matrix_queue.push_back(rotation_of_drag(dx, dy));
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // drain the pipe, then load the register
   task automatic write_rate(logic [23:0] val);
      req_valid <= 1'b0;
      while (matrix_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      rad_per_unit = val;
   endtask

   // receiver: random stall per result, drawn at the falling edge
   initial begin
      int wait_n;
      @(negedge clock);
      forever begin
         wait_n = stall_mode ? $urandom_range(0, 4) : 0;
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // checker: compares every accepted result with the oldest prediction
   always @(posedge clock) begin
      q16_type got [9];
      matrix_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (matrix_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result matrix");
         end else begin
            want = matrix_queue.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (got[k] !== want.m[k]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("m%0d%0d mismatch: expected %0d got %0d",
                              k / 3, k % 3, want.m[k], got[k]);
               end
            end
         end
      end
   end

   // watchdog: cycles with no accepted request or result
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      logic [15:0] edges [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
      send_drag(16'h0000, 16'h0000);           // zero drag gives identity
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) send_drag(edges[i], edges[j + 2]);
      send_drag(16'h8000, 16'h8000);
      send_drag(16'h7FFF, 16'h7FFF);
      send_drag(16'h8000, 16'h7FFF);
   endtask

   task automatic test_random(int count);
      logic [15:0] dx, dy;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: begin dx = 16'($urandom); dy = 16'($urandom); end
            1: begin dx = 16'($signed($urandom_range(0, 64)) - 32);
                     dy = 16'($signed($urandom_range(0, 64)) - 32); end
            2: begin dx = 16'($urandom); dy = '0; end
            default: begin dx = '0; dy = 16'($urandom); end
         endcase
         send_drag(dx, dy);
      end
   endtask

   // back-to-back drags with the receiver always ready
   task automatic test_streaming(int count);
      stall_mode = 1'b0;
      for (int i = 0; i < count; i++) begin
         req_valid <= 1'b1;
         req_drag_x <= 16'($urandom);
         req_drag_y <= 16'($urandom);
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         matrix_queue.push_back(rotation_of_drag(req_drag_x, req_drag_y));
         @(negedge clock);
      end
      stall_mode = 1'b1;
   endtask

   initial begin
      rad_per_unit = APU_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300);
      write_rate(24'd0);
      test_directed();
      test_random(150);
      write_rate(24'hFFFFFF);
      test_directed();
      test_random(200);
      write_rate(24'($urandom));
      test_random(200);
      test_streaming(150);
      write_rate(24'd1);
      test_random(100);
      req_valid <= 1'b0;
      while (matrix_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

`default_nettype wire
